// ----- src/mavg_pkg.sv -----
// ----------------------------------------------------------------------------
// mavg_pkg
// Shared constants, types and codes for the moving-average change reporter.
// ----------------------------------------------------------------------------
package mavg_pkg;

  // Filter geometry
  localparam int AVG_DEPTH   = 16;
  localparam int AVG_LOG2    = 4;
  localparam int SAMPLE_BITS = 12;

  localparam int SLOT_W  = $clog2(AVG_DEPTH);
  localparam int TOTAL_W = SAMPLE_BITS + $clog2(AVG_DEPTH);

  // Field widths fixed by the channel formats
  localparam int OUT_VALUE_W = 12;
  localparam int CHAN_W      = 8;
  localparam int SENS_W      = 8;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SENSITIVITY = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_ID  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_POLL   = 2'd1,
    OP_FORCE  = 2'd2,
    OP_BASE   = 2'd3
  } op_t;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [TOTAL_W-1:0]     total_t;

  // Request held in the update stage
  typedef struct packed {
    logic    valid;
    op_t     opcode;
    sample_t sample;
  } upd_req_t;

  // Ring write-back
  typedef struct packed {
    logic    en;
    slot_t   slot;
    sample_t data;
  } ring_wr_t;

endpackage

// ----- src/mavg_in_if.sv -----
// ----------------------------------------------------------------------------
// mavg_in_if
// Input request channel: opcode and converter sample.
// ----------------------------------------------------------------------------
interface mavg_in_if;
  import mavg_pkg::*;

  logic    valid;
  logic    ready;
  op_t     opcode;
  sample_t sample;

  modport source (output valid, output opcode, output sample, input ready);
  modport sink   (input valid, input opcode, input sample, output ready);
endinterface

// ----- src/mavg_out_if.sv -----
// ----------------------------------------------------------------------------
// mavg_out_if
// Result channel: reported average and channel number.
// ----------------------------------------------------------------------------
interface mavg_out_if;
  import mavg_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OUT_VALUE_W-1:0] average_value;
  logic [CHAN_W-1:0]      channel;

  modport source (output valid, output average_value, output channel, input ready);
  modport sink   (input valid, input average_value, input channel, output ready);
endinterface

// ----- src/mavg_cfg_if.sv -----
// ----------------------------------------------------------------------------
// mavg_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface mavg_cfg_if;
  import mavg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- src/mavg_ram.sv -----
// ----------------------------------------------------------------------------
// mavg_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mavg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- src/mavg_ring.sv -----
// ----------------------------------------------------------------------------
// mavg_ring
// Sample ring: write slot pointer, per-entry valid bits and the ring RAM.
// Reads the oldest entry when a sample request is accepted.
// ----------------------------------------------------------------------------
module mavg_ring (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               rd_en,
  input  mavg_pkg::ring_wr_t wr,
  output mavg_pkg::slot_t    slot,
  output mavg_pkg::sample_t  old_sample
);
  import mavg_pkg::*;

  slot_t                slot_r;
  slot_t                slot_nxt;
  logic [AVG_DEPTH-1:0] vld_r;
  logic                 rd_vld_r;
  sample_t              ram_q;

  // Next write slot, wraps after the last entry
  always_comb begin
    if (slot_r == SLOT_W'(AVG_DEPTH - 1)) begin
      slot_nxt = '0;
    end else begin
      slot_nxt = slot_r + SLOT_W'(1);
    end
  end

  // Pointer and valid bits; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r   <= '0;
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (rd_en) begin
        slot_r   <= slot_nxt;
        rd_vld_r <= vld_r[slot_r];
      end
      if (wr.en) begin
        vld_r[wr.slot] <= 1'b1;
      end
    end
  end

  mavg_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (AVG_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr.en),
    .wr_addr (wr.slot),
    .wr_data (wr.data),
    .rd_en   (rd_en),
    .rd_addr (slot_r),
    .rd_data (ram_q)
  );

  assign slot       = slot_r;
  assign old_sample = rd_vld_r ? ram_q : '0;

endmodule

// ----- src/mavg_acc.sv -----
// ----------------------------------------------------------------------------
// mavg_acc
// Update stage: running total, average, deadband compare, last reported
// value and the result output register.
// ----------------------------------------------------------------------------
module mavg_acc (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mavg_pkg::upd_req_t          req,
  input  mavg_pkg::sample_t           old_sample,
  input  logic [mavg_pkg::SENS_W-1:0] sens,
  input  logic [mavg_pkg::CHAN_W-1:0] chan,
  output logic                        adv,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [mavg_pkg::OUT_VALUE_W-1:0] out_value,
  output logic [mavg_pkg::CHAN_W-1:0] out_chan
);
  import mavg_pkg::*;

  total_t                 total_r;
  sample_t                last_r;
  logic                   out_valid_r;
  logic [OUT_VALUE_W-1:0] out_value_r;
  logic [CHAN_W-1:0]      out_chan_r;

  total_t  shifted;
  sample_t avg;
  sample_t diff;
  logic    report;
  logic    fire;

  // Average with saturation to the sample range
  always_comb begin
    shifted = total_r >> AVG_LOG2;
    if (shifted > TOTAL_W'({SAMPLE_BITS{1'b1}})) begin
      avg = '1;
    end else begin
      avg = shifted[SAMPLE_BITS-1:0];
    end
    diff = (avg >= last_r) ? (avg - last_r) : (last_r - avg);
  end

  // Report decision; stall only when a report meets a full output register
  assign report = req.valid &&
                  ((req.opcode == OP_FORCE) ||
                   ((req.opcode == OP_POLL) && (diff >= SAMPLE_BITS'(sens))));
  assign adv    = !report || !out_valid_r || out_ready;
  assign fire   = req.valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // Running total: drop oldest, add newest
      if (fire && (req.opcode == OP_SAMPLE)) begin
        total_r <= total_r - TOTAL_W'(old_sample) + TOTAL_W'(req.sample);
      end
      // Baseline or report updates the last value
      if (fire && ((req.opcode == OP_BASE) || report)) begin
        last_r <= avg;
      end
      // Output register
      if (fire && report) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (fire && report) begin
      out_value_r <= OUT_VALUE_W'(avg);
      out_chan_r  <= chan;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_chan  = out_chan_r;

endmodule

// ----- src/moving_average_change_reporter.sv -----
// ----------------------------------------------------------------------------
// moving_average_change_reporter
// Moving average over the last AVG_DEPTH converter samples with a deadband
// change reporter.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   request channel. Opcode sample writes a new reading into the
//           ring, poll reports the average when it moved by at least the
//           sensitivity, force always reports, baseline stores the current
//           average as the last reported value. Only poll and force can
//           produce a result.
//   out_ch  result channel: average_value and channel number.
//   cfg_ch  register writes: index 0 sensitivity, index 1 channel id; other
//           indexes are ignored. cfg_ch.ready is always high.
// Path: a reporting request passes the request register, then the result
//   register, before it shows on out_ch.
// Throughput: one request per cycle while the update stage does not stall,
//   set by the ring RAM with one read and one write port.
// Reset: write slot, per-entry valid bits, running total, last value, settings
//   and result valid clear; ring RAM entries read as zero until written.
// Stall: the result register holds while out_ch.ready is low; a request that
//   must report waits in the update stage and in_ch.ready drops.
// ----------------------------------------------------------------------------
module moving_average_change_reporter (
  input logic  clk,
  input logic  rst_n,
  mavg_in_if.sink    in_ch,
  mavg_out_if.source out_ch,
  mavg_cfg_if.sink   cfg_ch
);
  import mavg_pkg::*;

  logic [SENS_W-1:0] sens_r;
  logic [CHAN_W-1:0] chan_r;
  upd_req_t          req_r;

  logic     in_fire;
  logic     adv;
  slot_t    ring_slot;
  slot_t    upd_slot_r;
  sample_t  old_sample;
  ring_wr_t wr;

  // Configuration registers
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r <= '0;
      chan_r <= '0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_SENSITIVITY: sens_r <= SENS_W'(cfg_ch.data);
        CFG_CHANNEL_ID:  chan_r <= CHAN_W'(cfg_ch.data);
        default: ;
      endcase
    end
  end

  // Accept stage
  assign in_ch.ready = !req_r.valid || adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r.valid <= 1'b0;
    end else if (in_fire) begin
      req_r.valid <= 1'b1;
    end else if (adv) begin
      req_r.valid <= 1'b0;
    end
    // Payload needs no reset
    if (in_fire) begin
      req_r.opcode <= in_ch.opcode;
      req_r.sample <= in_ch.sample;
      upd_slot_r   <= ring_slot;
    end
  end

  // Ring write-back from the update stage
  always_comb begin
    wr.en   = req_r.valid && adv && (req_r.opcode == OP_SAMPLE);
    wr.slot = upd_slot_r;
    wr.data = req_r.sample;
  end

  mavg_ring u_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (in_fire && (in_ch.opcode == OP_SAMPLE)),
    .wr         (wr),
    .slot       (ring_slot),
    .old_sample (old_sample)
  );

  mavg_acc u_acc (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req_r),
    .old_sample (old_sample),
    .sens       (sens_r),
    .chan       (chan_r),
    .adv        (adv),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_value  (out_ch.average_value),
    .out_chan   (out_ch.channel)
  );

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the moving-average change reporter. Requests go
// out from a queue through a clocked driver. A clocked monitor keeps its own
// copy of the ring, total and last value, predicts each report and compares
// the reports that come back in order. Sensitivity and channel id change
// between phases while the block is idle. Idling on both channels and one
// long result hold-off are used to push the block into back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import mavg_pkg::*;

  localparam int CLK_PERIOD     = 20;
  localparam int RESET_CYCLES   = 4;
  localparam int DRAIN_CYCLES   = 6;
  localparam int HOLD_CYCLES    = 120;
  localparam int STALL_LIMIT    = 2000;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 200;
  localparam int PRESSURE_ITEMS = 48;
  localparam int MAX_PRINTED    = 40;
  localparam int SAMPLE_MAX     = (1 << SAMPLE_BITS) - 1;

  // Indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LOW  = CFG_CHANNEL_ID + 1'b1;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HIGH = '1;

  typedef struct {
    op_t     op;
    sample_t sample;
  } request_t;

  typedef struct {
    logic [OUT_VALUE_W-1:0] value;
    logic [CHAN_W-1:0]      channel;
  } report_t;

  typedef struct {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk = 1'b0;
  logic rst_n;

  mavg_in_if  in_ch();
  mavg_out_if out_ch();
  mavg_cfg_if cfg_ch();

  moving_average_change_reporter u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Request, register write and report queues
  request_t   pending_requests [$];
  reg_write_t pending_writes [$];
  report_t    expected_reports [$];

  // Predicted filter state and registers
  sample_t           avg_ring [AVG_DEPTH];
  total_t            avg_total;
  int                avg_slot;
  sample_t           last_avg;
  logic [SENS_W-1:0] sens_setting;
  logic [CHAN_W-1:0] chan_setting;

  int error_count    = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requests  = 0;
  int hold_served    = 0;
  int hold_left      = 0;

  task automatic flag_mismatch(string what, int got, int want);
    error_count++;
    if (error_count <= MAX_PRINTED)
      $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Average of the ring, clipped to the sample range
  function automatic sample_t current_average();
    int avg;
    avg = int'(avg_total) >> AVG_LOG2;
    if (avg > SAMPLE_MAX)
      avg = SAMPLE_MAX;
    return sample_t'(avg);
  endfunction

  // Advance the predicted state by one accepted request
  task automatic apply_request(op_t op, sample_t smp);
    sample_t avg;
    int      diff;
    report_t rep;
    if (op == OP_SAMPLE) begin
      avg_total = avg_total - total_t'(avg_ring[avg_slot]) + total_t'(smp);
      avg_ring[avg_slot] = smp;
      avg_slot = (avg_slot == AVG_DEPTH - 1) ? 0 : avg_slot + 1;
    end else begin
      avg  = current_average();
      diff = (avg >= last_avg) ? int'(avg) - int'(last_avg) : int'(last_avg) - int'(avg);
      if (op == OP_BASE) begin
        last_avg = avg;
      end else if (op == OP_FORCE || diff >= int'(sens_setting)) begin
        last_avg    = avg;
        rep.value   = avg;
        rep.channel = chan_setting;
        expected_reports.push_back(rep);
      end
    end
  endtask

  task automatic push_request(op_t op, sample_t smp);
    request_t req;
    req.op     = op;
    req.sample = smp;
    pending_requests.push_back(req);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    reg_write_t wr;
    wr.index = index;
    wr.data  = data;
    pending_writes.push_back(wr);
  endtask

  // Wait until everything sent has been accepted and answered
  task automatic settle();
    do @(posedge clk);
    while (pending_requests.size() != 0 || pending_writes.size() != 0 ||
           in_ch.valid || cfg_ch.valid || expected_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Driver: request channel with random gaps, register writes back to back
  always @(posedge clk) begin
    request_t   req;
    reg_write_t wr;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      cfg_ch.valid <= 1'b0;
    end else begin
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req = pending_requests.pop_front();
          in_ch.valid  <= 1'b1;
          in_ch.opcode <= req.op;
          in_ch.sample <= req.sample;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      if (!cfg_ch.valid || cfg_ch.ready) begin
        if (pending_writes.size() != 0) begin
          wr = pending_writes.pop_front();
          cfg_ch.valid <= 1'b1;
          cfg_ch.index <= wr.index;
          cfg_ch.data  <= wr.data;
        end else begin
          cfg_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long result hold-off, started on request from the stimulus
  always @(posedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left   <= HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: check reports, track requests and register writes
  always @(posedge clk) begin
    report_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_reports.size() == 0) begin
          flag_mismatch("unexpected report, average_value",
                        int'(out_ch.average_value), 0);
        end else begin
          want = expected_reports.pop_front();
          if (out_ch.average_value !== want.value)
            flag_mismatch("average_value", int'(out_ch.average_value), int'(want.value));
          if (out_ch.channel !== want.channel)
            flag_mismatch("channel", int'(out_ch.channel), int'(want.channel));
        end
      end
      if (in_ch.valid && in_ch.ready)
        apply_request(in_ch.opcode, in_ch.sample);
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CFG_SENSITIVITY)
          sens_setting = cfg_ch.data;
        else if (cfg_ch.index == CFG_CHANNEL_ID)
          chan_setting = cfg_ch.data;
      end
    end
    out_ch.ready <= rst_n && hold_left == 0 && ($urandom_range(99) >= recv_stall_pct);
  end

  // Watchdog on cycles with no handshake anywhere
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= STALL_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  // Stimulus
  initial begin
    int  level;
    int  span;
    int  value;
    int  pick;
    int  sens_plan [PHASES];
    op_t op;

    in_ch.valid   = 1'b0;
    in_ch.opcode  = OP_SAMPLE;
    in_ch.sample  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = '0;
    cfg_ch.data   = '0;
    out_ch.ready  = 1'b0;
    foreach (avg_ring[i]) avg_ring[i] = '0;
    avg_total     = '0;
    avg_slot      = 0;
    last_avg      = '0;
    sens_setting  = '0;
    chan_setting  = '0;
    send_idle_pct  = 9;
    recv_stall_pct = 65;
    sens_plan = '{0, 255, 1, 16, -1, 64, 4, -1};

    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Zero sensitivity out of reset: even an unchanged average reports
    push_request(OP_POLL, '0);
    push_request(OP_FORCE, '0);
    push_request(OP_BASE, '0);
    // Fill the ring at full scale, then wrap and overwrite the oldest entry
    repeat (AVG_DEPTH) push_request(OP_SAMPLE, sample_t'(SAMPLE_MAX));
    push_request(OP_FORCE, '0);
    push_request(OP_SAMPLE, '0);
    // Sample field must be ignored on non-sample requests
    push_request(OP_POLL, sample_t'(SAMPLE_MAX));
    push_request(OP_BASE, sample_t'(SAMPLE_MAX));
    push_request(OP_POLL, '0);
    settle();

    // Register extremes; writes to unused indexes must change nothing
    write_reg(CFG_SENSITIVITY, '1);
    write_reg(CFG_CHANNEL_ID, '1);
    write_reg(CFG_UNUSED_LOW, '0);
    write_reg(CFG_UNUSED_HIGH, '0);
    settle();
    push_request(OP_POLL, '0);
    push_request(OP_FORCE, '0);

    // Random phases: drifting samples mixed with jumps and extremes
    level = SAMPLE_MAX / 2;
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      if (phase == 3) begin
        send_idle_pct  = 65;
        recv_stall_pct = 9;
      end else if (phase == 6) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      write_reg(CFG_SENSITIVITY,
                CFG_DATA_W'((sens_plan[phase] < 0) ? $urandom_range(255) : sens_plan[phase]));
      write_reg(CFG_CHANNEL_ID, CFG_DATA_W'($urandom_range(255)));
      settle();
      span = 1 << $urandom_range(2, 9);
      repeat (PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          pick = $urandom_range(99);
          if (pick < 10)
            value = pick[0] ? SAMPLE_MAX : 0;
          else if (pick < 30)
            value = $urandom_range(SAMPLE_MAX);
          else
            value = level + int'($urandom_range(2 * span)) - span;
          if (value < 0)
            value = 0;
          else if (value > SAMPLE_MAX)
            value = SAMPLE_MAX;
          level = value;
          push_request(OP_SAMPLE, sample_t'(value));
        end else begin
          op = (pick < 78) ? OP_POLL : ((pick < 90) ? OP_FORCE : OP_BASE);
          push_request(op, sample_t'($urandom));
        end
      end
    end

    // Back-pressure: results held off while reporting requests keep coming
    settle();
    write_reg(CFG_SENSITIVITY, '0);
    settle();
    @(posedge clk);
    hold_requests <= hold_requests + 1;
    repeat (PRESSURE_ITEMS)
      push_request($urandom_range(1) ? OP_FORCE : OP_SAMPLE, sample_t'($urandom));
    settle();

    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
src/mavg_pkg.sv
src/mavg_in_if.sv
src/mavg_out_if.sv
src/mavg_cfg_if.sv
src/mavg_ram.sv
src/mavg_ring.sv
src/mavg_acc.sv
src/moving_average_change_reporter.sv
bench/testbench.sv
